[hw/rtl/psd_pkg.sv]
// Shared types for the point to segment distance block.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package psd_pkg;

    // Which part of the segment lies nearest to the query point
    typedef enum logic [1:0] {
        REGION_DEGEN    = 2'd0,
        REGION_START    = 2'd1,
        REGION_END      = 2'd2,
        REGION_INTERIOR = 2'd3
    } region_t;

endpackage

[hw/rtl/point_segment_distance_top.sv]
// Point to segment distance, 2-D signed fixed point, fully pipelined.
// Depends on psd_pkg (region codes).
`timescale 1ns / 1ps
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------------
//  item     | item_valid / item_stall   | start_x/y, end_x/y, query_x/y (signed)
//  result   | result_valid/result_stall | distance (unsigned), region (2 bits)
//
//  One beat enters per cycle while item_stall is low. The pipe has five
//  arithmetic stages, a restoring divider of 2*COORD_WIDTH+2 stages (a load
//  stage, then one bit per stage), and a square root of COORD_WIDTH+2 stages
//  (a load stage, then one root bit per stage).
//  The whole pipe advances as one unit; it holds only when the output register
//  has a beat and result_stall is high, and item_stall is raised just then.
//  Reset clears the valid bits only; payload registers carry no reset.
//
//  Math: d = end - start, w = query - start, dot = w.d, len2 = d.d.
//  Endpoint and degenerate cases take isqrt(|w|^2) or isqrt(|query-end|^2);
//  the interior case takes isqrt(floor(cross^2 / len2)). The endpoint and
//  degenerate cases run through the same divider with a divisor of one.

module point_segment_distance_top #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] end_x,
    input  logic signed [COORD_WIDTH-1:0] end_y,
    input  logic signed [COORD_WIDTH-1:0] query_x,
    input  logic signed [COORD_WIDTH-1:0] query_y,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic        [COORD_WIDTH:0]   distance,
    output logic        [1:0]             region
);
    import psd_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int DW  = CW + 1;       // coordinate differences
    localparam int PW  = 2 * DW;       // products of differences
    localparam int SW  = PW + 1;       // sums of two products
    localparam int CXW = 2 * CW + 1;   // magnitude of cross product
    localparam int HW  = CW + 1;       // low half of the cross magnitude
    localparam int AW  = CXW - HW;     // high half of the cross magnitude
    localparam int LW  = 2 * CW + 1;   // squared length
    localparam int QW  = 2 * CW + 1;   // quotient, i.e. squared distance
    localparam int NW  = 2 * CXW;      // dividend
    localparam int OW  = CW + 1;       // distance
    localparam int RDW = 2 * OW;       // padded radicand
    localparam int RW  = OW + 3;       // square root remainder

    // Advance everything unless a finished beat is held at the output
    logic advance;
    assign advance    = !(result_valid && result_stall);
    assign item_stall = !advance;

    // ---------------- stage 1: differences ----------------
    logic                 v1_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, wx_reg, wy_reg, vx_reg, vy_reg;

    // ---------------- stage 2: products ----------------
    logic                 v2_reg;
    logic signed [PW-1:0] dxx_reg, dyy_reg, wxdx_reg, wydy_reg, wxdy_reg, wydx_reg;
    logic signed [PW-1:0] wxx_reg, wyy_reg, vxx_reg, vyy_reg;

    // ---------------- stage 3: sums ----------------
    logic                 v3_reg;
    logic signed [SW-1:0] len2_reg, dot_reg, cross_reg, ws2_reg, vs2_reg;

    // ---------------- stage 4: classify ----------------
    logic                 v4_reg;
    region_t              rg4_reg, rg4_next;
    logic        [CXW-1:0] cx_reg, cx_next;
    logic        [QW-1:0]  sqd4_reg, sqd4_next;
    logic        [LW-1:0]  len4_reg;
    logic signed [SW-1:0]  cross_abs;

    // ---------------- stage 5: partial products of cross^2 ----------------
    logic                     v5_reg;
    region_t                  rg5_reg;
    logic [2*AW-1:0]          aa_reg;
    logic [AW+HW-1:0]         ab_reg;
    logic [2*HW-1:0]          bb_reg;
    logic [QW-1:0]            sqd5_reg;
    logic [LW-1:0]            len5_reg;
    logic [AW-1:0]            cx_hi;
    logic [HW-1:0]            cx_lo;

    // ---------------- divider: one quotient bit per stage ----------------
    logic          div_v_reg   [0:QW];
    region_t       div_rg_reg  [0:QW];
    logic [LW-1:0] div_rem_reg [0:QW];
    logic [QW-1:0] div_nlo_reg [0:QW];
    logic [QW-1:0] div_quo_reg [0:QW];
    logic [LW-1:0] div_len_reg [0:QW];
    logic [LW-1:0] div_rem_next [1:QW];
    logic [QW-1:0] div_quo_next [1:QW];
    logic [NW-1:0] dividend;
    logic [LW-1:0] divisor;

    // ---------------- square root: one root bit per stage ----------------
    logic           sq_v_reg    [0:OW];
    region_t        sq_rg_reg   [0:OW];
    logic [RDW-1:0] sq_rad_reg  [0:OW];
    logic [RW-1:0]  sq_rem_reg  [0:OW];
    logic [OW-1:0]  sq_root_reg [0:OW];
    logic [RW-1:0]  sq_rem_next  [1:OW];
    logic [OW-1:0]  sq_root_next [1:OW];

    // Classification: degenerate, before start, past end, or interior
    always_comb
    begin
        cross_abs = cross_reg[SW-1] ? -cross_reg : cross_reg;
        cx_next   = cross_abs[CXW-1:0];
        if (len2_reg == '0)
        begin
            rg4_next = REGION_DEGEN;
        end
        else if (dot_reg[SW-1])
        begin
            rg4_next = REGION_START;
        end
        else if (dot_reg > len2_reg)
        begin
            rg4_next = REGION_END;
        end
        else
        begin
            rg4_next = REGION_INTERIOR;
        end
        sqd4_next = (rg4_next == REGION_END) ? vs2_reg[QW-1:0] : ws2_reg[QW-1:0];
    end

    assign cx_hi = cx_reg[CXW-1:HW];
    assign cx_lo = cx_reg[HW-1:0];

    // Interior: cross^2 over len2; elsewhere squared distance over one
    always_comb
    begin
        if (rg5_reg == REGION_INTERIOR)
        begin
            dividend = (NW'(aa_reg) << (2 * HW)) + (NW'(ab_reg) << (HW + 1))
                     + NW'(bb_reg);
            divisor  = len5_reg;
        end
        else
        begin
            dividend = NW'(sqd5_reg);
            divisor  = LW'(1);
        end
    end

    // Restoring division steps
    always_comb
    begin
        logic [LW:0] trial;
        logic        ge;
        for (int i = 1; i <= QW; i++)
        begin
            trial = {div_rem_reg[i-1], div_nlo_reg[i-1][QW-1]};
            ge    = (trial >= {1'b0, div_len_reg[i-1]});
            div_rem_next[i] = ge ? LW'(trial - {1'b0, div_len_reg[i-1]}) : trial[LW-1:0];
            div_quo_next[i] = {div_quo_reg[i-1][QW-2:0], ge};
        end
    end

    // Digit-by-digit square root steps
    always_comb
    begin
        logic [RW-1:0] remt;
        logic [RW-1:0] trial;
        logic          ge;
        for (int i = 1; i <= OW; i++)
        begin
            remt  = {sq_rem_reg[i-1][RW-3:0], sq_rad_reg[i-1][RDW-1:RDW-2]};
            trial = RW'({sq_root_reg[i-1], 2'b01});
            ge    = (remt >= trial);
            sq_rem_next[i]  = ge ? remt - trial : remt;
            sq_root_next[i] = {sq_root_reg[i-1][OW-2:0], ge};
        end
    end

    // Valid bits: cleared by reset, advance with the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            for (int i = 0; i <= QW; i++)
            begin
                div_v_reg[i] <= 1'b0;
            end
            for (int i = 0; i <= OW; i++)
            begin
                sq_v_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            v1_reg       <= item_valid;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            v5_reg       <= v4_reg;
            div_v_reg[0] <= v5_reg;
            for (int i = 1; i <= QW; i++)
            begin
                div_v_reg[i] <= div_v_reg[i-1];
            end
            sq_v_reg[0] <= div_v_reg[QW];
            for (int i = 1; i <= OW; i++)
            begin
                sq_v_reg[i] <= sq_v_reg[i-1];
            end
        end
    end

    // Payload: hold on stall, otherwise shift one stage
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dx_reg <= DW'(end_x) - DW'(start_x);
            dy_reg <= DW'(end_y) - DW'(start_y);
            wx_reg <= DW'(query_x) - DW'(start_x);
            wy_reg <= DW'(query_y) - DW'(start_y);
            vx_reg <= DW'(query_x) - DW'(end_x);
            vy_reg <= DW'(query_y) - DW'(end_y);

            dxx_reg  <= dx_reg * dx_reg;
            dyy_reg  <= dy_reg * dy_reg;
            wxdx_reg <= wx_reg * dx_reg;
            wydy_reg <= wy_reg * dy_reg;
            wxdy_reg <= wx_reg * dy_reg;
            wydx_reg <= wy_reg * dx_reg;
            wxx_reg  <= wx_reg * wx_reg;
            wyy_reg  <= wy_reg * wy_reg;
            vxx_reg  <= vx_reg * vx_reg;
            vyy_reg  <= vy_reg * vy_reg;

            len2_reg  <= SW'(dxx_reg) + SW'(dyy_reg);
            dot_reg   <= SW'(wxdx_reg) + SW'(wydy_reg);
            cross_reg <= SW'(wxdy_reg) - SW'(wydx_reg);
            ws2_reg   <= SW'(wxx_reg) + SW'(wyy_reg);
            vs2_reg   <= SW'(vxx_reg) + SW'(vyy_reg);

            rg4_reg  <= rg4_next;
            cx_reg   <= cx_next;
            sqd4_reg <= sqd4_next;
            len4_reg <= len2_reg[LW-1:0];

            rg5_reg  <= rg4_reg;
            aa_reg   <= cx_hi * cx_hi;
            ab_reg   <= cx_hi * cx_lo;
            bb_reg   <= cx_lo * cx_lo;
            sqd5_reg <= sqd4_reg;
            len5_reg <= len4_reg;

            // quotient fits QW bits, so the top of the dividend is below the divisor
            div_rg_reg[0]  <= rg5_reg;
            div_rem_reg[0] <= dividend[NW-1:QW];
            div_nlo_reg[0] <= dividend[QW-1:0];
            div_quo_reg[0] <= '0;
            div_len_reg[0] <= divisor;
            for (int i = 1; i <= QW; i++)
            begin
                div_rg_reg[i]  <= div_rg_reg[i-1];
                div_rem_reg[i] <= div_rem_next[i];
                div_nlo_reg[i] <= div_nlo_reg[i-1] << 1;
                div_quo_reg[i] <= div_quo_next[i];
                div_len_reg[i] <= div_len_reg[i-1];
            end

            sq_rg_reg[0]   <= div_rg_reg[QW];
            sq_rad_reg[0]  <= RDW'(div_quo_reg[QW]);
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            for (int i = 1; i <= OW; i++)
            begin
                sq_rg_reg[i]   <= sq_rg_reg[i-1];
                sq_rad_reg[i]  <= sq_rad_reg[i-1] << 2;
                sq_rem_reg[i]  <= sq_rem_next[i];
                sq_root_reg[i] <= sq_root_next[i];
            end
        end
    end

    assign result_valid = sq_v_reg[OW];
    assign distance     = sq_root_reg[OW];
    assign region       = sq_rg_reg[OW];

endmodule

[hw/rtl/psd_checker.sv]
// Port-level checks for point_segment_distance_top, bound to every instance.
// Depends on psd_pkg.
`timescale 1ns / 1ps

module psd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       item_stall,
    input logic       result_valid,
    input logic       result_stall,
    input logic [1:0] region
);
    import psd_pkg::*;

    // Hold a stalled result beat
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(region))
        else $error("stalled result beat changed");

    // Stall the input only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("input stalled without a held result");

    // Take input whenever the output side is free
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("input stalled with an empty output");

    // Drop nothing: a held result beat always stalls the input
    a_stall_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |-> item_stall)
        else $error("input taken while result held");

endmodule

bind point_segment_distance_top psd_checker u_psd_checker (.*);
